// ----- src/mng_pkg.sv -----
// ----------------------------------------------------------------------------
// mng_pkg
// Shared constants, register indexes and types of the Moore neighbourhood
// generator.
// ----------------------------------------------------------------------------
package mng_pkg;

  localparam int MAX_DIMS    = 3;
  localparam int COORD_BITS  = 12;
  localparam int OFF_BITS    = 2;
  localparam int BOUND_BITS  = COORD_BITS + 1;
  localparam int IN_TDATA_W  = ((MAX_DIMS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = MAX_DIMS * (OFF_BITS + COORD_BITS);
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = BOUND_BITS;
  localparam int DIMS_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LOW_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LOW_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LOW_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HIGH_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HIGH_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HIGH_2 = 3'd6;

  localparam logic [DIMS_W-1:0]     NUM_DIMS_RST  = 2'd3;
  localparam logic [BOUND_BITS-1:0] GRID_HIGH_RST = BOUND_BITS'(1 << COORD_BITS);

  typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_vec_t;
  typedef logic [MAX_DIMS-1:0][OFF_BITS-1:0]   off_vec_t;

  // one classified request: centre plus which sides of the window survive
  typedef struct packed {
    coord_vec_t          center;
    logic [MAX_DIMS-1:0] act;
    logic [MAX_DIMS-1:0] has_lo;
    logic [MAX_DIMS-1:0] has_hi;
  } win_desc_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ----- src/mng_front.sv -----
// ----------------------------------------------------------------------------
// mng_front
// Configuration registers and window classification of each incoming centre.
// ----------------------------------------------------------------------------
module mng_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mng_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mng_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mng_pkg::IN_TDATA_W-1:0]     in_tdata,
  output mng_pkg::hs_t                       push,
  input  logic                               push_ready,
  output mng_pkg::win_desc_t                 push_desc
);
  import mng_pkg::*;

  logic [DIMS_W-1:0]                    num_dims_r, num_dims_nxt;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0]  grid_low_r, grid_low_nxt;
  logic [MAX_DIMS-1:0][BOUND_BITS-1:0]  grid_high_r, grid_high_nxt;
  logic [MAX_DIMS-1:0]                  act;
  logic [COORD_BITS-1:0]                c;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_dims_nxt  = num_dims_r;
    grid_low_nxt  = grid_low_r;
    grid_high_nxt = grid_high_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_DIMS:    num_dims_nxt     = cfg_data[DIMS_W-1:0];
        REG_GRID_LOW_0:  grid_low_nxt[0]  = cfg_data[COORD_BITS-1:0];
        REG_GRID_LOW_1:  grid_low_nxt[1]  = cfg_data[COORD_BITS-1:0];
        REG_GRID_LOW_2:  grid_low_nxt[2]  = cfg_data[COORD_BITS-1:0];
        REG_GRID_HIGH_0: grid_high_nxt[0] = cfg_data;
        REG_GRID_HIGH_1: grid_high_nxt[1] = cfg_data;
        REG_GRID_HIGH_2: grid_high_nxt[2] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NUM_DIMS_RST;
      for (int d = 0; d < MAX_DIMS; d++) begin
        grid_low_r[d]  <= '0;
        grid_high_r[d] <= GRID_HIGH_RST;
      end
    end else begin
      num_dims_r  <= num_dims_nxt;
      grid_low_r  <= grid_low_nxt;
      grid_high_r <= grid_high_nxt;
    end
  end

  // a count of zero behaves as one
  always_comb begin
    case (num_dims_r)
      2'd0, 2'd1: act = 3'b001;
      2'd2:       act = 3'b011;
      default:    act = 3'b111;
    endcase
  end

  always_comb begin
    c = '0;
    push_desc.act = act;
    for (int d = 0; d < MAX_DIMS; d++) begin
      c = in_tdata[d*COORD_BITS +: COORD_BITS];
      push_desc.center[d] = c;
      push_desc.has_lo[d] = act[d] && (c != grid_low_r[d]) && (c != '0);
      push_desc.has_hi[d] = act[d] && (({1'b0, c} + BOUND_BITS'(1)) != grid_high_r[d])
                            && (c != '1);
    end
  end

  assign push.valid = in_tvalid;
  assign push.ready = push_ready;
  assign in_tready  = push_ready;

endmodule

// ----- src/mng_queue.sv -----
// ----------------------------------------------------------------------------
// mng_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module mng_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mng_pkg::hs_t        push,
  output logic                push_ready,
  input  mng_pkg::win_desc_t  push_desc,
  output logic                pop_valid,
  input  logic                pop,
  output mng_pkg::win_desc_t  pop_desc
);
  import mng_pkg::*;

  win_desc_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

// ----- src/mng_back.sv -----
// ----------------------------------------------------------------------------
// mng_back
// Window walker: steps through the clipped window, last dimension fastest,
// one neighbour per cycle into the output register unless the output stalls.
// ----------------------------------------------------------------------------
module mng_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pop_valid,
  output logic                             pop,
  input  mng_pkg::win_desc_t               pop_desc,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mng_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import mng_pkg::*;

  logic                    busy_r, busy_nxt;
  win_desc_t               desc_r, desc_nxt;
  off_vec_t                off_r, off_nxt, off_step, off_min, off_max;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    carry, at_end, take;
  coord_vec_t              nb;

  // window corners as offsets: -1 / 0 at the bottom, 0 / +1 at the top
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      off_min[d] = desc_r.has_lo[d] ? 2'b11 : 2'b00;
      off_max[d] = desc_r.has_hi[d] ? 2'b01 : 2'b00;
    end
  end

  always_comb begin
    carry    = 1'b1;
    off_step = off_r;
    for (int d = MAX_DIMS-1; d >= 0; d--) begin
      if (carry) begin
        if (off_r[d] != off_max[d]) begin
          off_step[d] = off_r[d] + 2'b01;
          carry       = 1'b0;
        end else begin
          off_step[d] = off_min[d];
        end
      end
    end
    at_end = carry;
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      nb[d] = desc_r.act[d]
            ? desc_r.center[d] + {{(COORD_BITS-OFF_BITS){off_r[d][1]}}, off_r[d]}
            : '0;
    end
  end

  assign take = !out_valid_r || out_tready;

  always_comb begin
    busy_nxt      = busy_r;
    desc_nxt      = desc_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (busy_r && take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({nb, off_r});
      out_last_nxt  = at_end;
      off_nxt       = off_step;
      if (at_end) busy_nxt = 1'b0;
    end else if (!busy_r && pop_valid) begin
      pop      = 1'b1;
      desc_nxt = pop_desc;
      busy_nxt = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
        off_nxt[d] = pop_desc.has_lo[d] ? 2'b11 : 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/moore_neighborhood_generator.sv -----
// ----------------------------------------------------------------------------
// moore_neighborhood_generator
// Enumerates the clipped 3x3x3 Moore neighbourhood of a centre coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (index 0 num_dims, 1..3 grid_low_d, 4..6
//            grid_high_d); cfg_ready is always high. Write only while idle.
//   in_*   : one request per centre, tdata = {center_2, center_1, center_0}.
//   out_*  : one result per neighbour in row-major order (dimension 0
//            slowest), centre included, tlast on the final one of a run.
// Timing:
//   A request with n neighbours (1 to 27) holds the walker while it loads
//   and then emits every neighbour. An accepted request passes through the
//   queue and the walker's load before its first result is registered.
//   A two-entry queue lets the front take further requests while the walker
//   is busy; in_tready drops when the queue is full.
// Reset: synchronous, active low; clears the queue, walker and output
//   register, and loads num_dims = 3, grid_low = 0, grid_high = 4096.
// Stall: a held output keeps its data; the walker pauses until it is taken.
// ----------------------------------------------------------------------------
module moore_neighborhood_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mng_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mng_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // center_0, center_1, center_2, zero pad
  input  logic [mng_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // offset_0, offset_1, offset_2, neighbor_0, neighbor_1, neighbor_2, zero pad
  output logic [mng_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import mng_pkg::*;

  hs_t        push;
  logic       push_ready;
  win_desc_t  push_desc;
  logic       pop_valid, pop;
  win_desc_t  pop_desc;

  mng_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  mng_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_desc   (pop_desc)
  );

  mng_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_desc   (pop_desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/mng_checker.sv -----
// ----------------------------------------------------------------------------
// mng_checker
// Port-level checks of the Moore neighbourhood generator, bound to the top.
// ----------------------------------------------------------------------------
module mng_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mng_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             out_tlast
);
  import mng_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // nothing pending straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // offsets are only -1, 0 or +1
  a_off_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b10 && out_tdata[3:2] != 2'b10
                   && out_tdata[5:4] != 2'b10)
    else $error("illegal offset code");

  // the final cell of a run is the top corner: no negative offset
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1:0] != 2'b11 && out_tdata[3:2] != 2'b11
                                && out_tdata[5:4] != 2'b11)
    else $error("last result not at window top corner");

endmodule

bind moore_neighborhood_generator mng_checker u_mng_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- verif/tb_moore_neighborhood_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moore_neighborhood_generator
// Self-checking bench for the Moore neighbourhood generator. Centres go
// through the input stream under a series of grid settings. A local window
// enumerator forecasts every neighbour of each accepted centre. Each result
// on the output stream is checked field by field against the oldest forecast.
// Both stream sides are throttled at random; the rate changes per phase.
// ----------------------------------------------------------------------------
module tb_moore_neighborhood_generator;
  import mng_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 37;
  localparam int NUM_PHASES   = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
  localparam int BOUND_TOP    = (1 << BOUND_BITS) - 1;

  typedef struct packed {
    logic       last;
    coord_vec_t nbr;
    off_vec_t   off;
  } neighbor_cell_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // local copy of the register file
  logic [DIMS_W-1:0]     grid_dims = NUM_DIMS_RST;
  logic [COORD_BITS-1:0] grid_low [MAX_DIMS];
  logic [BOUND_BITS-1:0] grid_high[MAX_DIMS];

  coord_vec_t     pending_centres[$];
  neighbor_cell_t expected_cells[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  moore_neighborhood_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Forecast every cell of the clipped window, dimension 0 slowest.
  task automatic enumerate_window(input coord_vec_t c);
    int lo[MAX_DIMS];
    int hi[MAX_DIMS];
    int pos[MAX_DIMS];
    int active;
    int total;
    int n;
    neighbor_cell_t entry;
    active = (grid_dims == 0) ? 1 : int'(grid_dims);
    if (active > MAX_DIMS) active = MAX_DIMS;
    total = 1;
    n = 0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      lo[d] = int'(c[d]);
      hi[d] = int'(c[d]);
      if (d < active) begin
        if (c[d] != grid_low[d] && c[d] != 0) lo[d] = lo[d] - 1;
        if (int'(c[d]) + 1 != int'(grid_high[d]) && int'(c[d]) != COORD_TOP)
          hi[d] = hi[d] + 1;
      end
      total = total * (hi[d] - lo[d] + 1);
    end
    for (int p0 = lo[0]; p0 <= hi[0]; p0++)
      for (int p1 = lo[1]; p1 <= hi[1]; p1++)
        for (int p2 = lo[2]; p2 <= hi[2]; p2++) begin
          pos[0] = p0;
          pos[1] = p1;
          pos[2] = p2;
          for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < active) begin
              entry.off[d] = OFF_BITS'(pos[d] - int'(c[d]));
              entry.nbr[d] = COORD_BITS'(pos[d]);
            end else begin
              entry.off[d] = '0;
              entry.nbr[d] = '0;
            end
          end
          n++;
          entry.last = (n == total);
          expected_cells.push_back(entry);
        end
  endtask

  // driver: a new request may be loaded once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        enumerate_window(coord_vec_t'(in_tdata[MAX_DIMS*COORD_BITS-1:0]));
      if (!in_tvalid || in_tready) begin
        if (pending_centres.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_tdata  <= IN_TDATA_W'(pending_centres.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    neighbor_cell_t got;
    neighbor_cell_t want;
    logic bad;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.off  = out_tdata[MAX_DIMS*OFF_BITS-1:0];
        got.nbr  = out_tdata[OUT_FIELD_W-1:MAX_DIMS*OFF_BITS];
        got.last = out_tlast;
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: off=%h nbr=%h last=%b",
                     got.off, got.nbr, got.last);
        end else begin
          want = expected_cells.pop_front();
          bad = (got.last != want.last);
          for (int d = 0; d < MAX_DIMS; d++)
            if (got.off[d] != want.off[d] || got.nbr[d] != want.nbr[d]) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp off=%h nbr=%h last=%b, got off=%h nbr=%h last=%b",
                       want.off, want.nbr, want.last, got.off, got.nbr, got.last);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NUM_DIMS:    grid_dims    = DIMS_W'(value);
      REG_GRID_LOW_0:  grid_low[0]  = COORD_BITS'(value);
      REG_GRID_LOW_1:  grid_low[1]  = COORD_BITS'(value);
      REG_GRID_LOW_2:  grid_low[2]  = COORD_BITS'(value);
      REG_GRID_HIGH_0: grid_high[0] = BOUND_BITS'(value);
      REG_GRID_HIGH_1: grid_high[1] = BOUND_BITS'(value);
      REG_GRID_HIGH_2: grid_high[2] = BOUND_BITS'(value);
      default: ;
    endcase
  endtask

  task automatic program_grid(input int dims, input int lo[MAX_DIMS],
                              input int hi[MAX_DIMS]);
    write_reg(REG_NUM_DIMS, dims);
    write_reg(REG_GRID_LOW_0, lo[0]);
    write_reg(REG_GRID_LOW_1, lo[1]);
    write_reg(REG_GRID_LOW_2, lo[2]);
    write_reg(REG_GRID_HIGH_0, hi[0]);
    write_reg(REG_GRID_HIGH_1, hi[1]);
    write_reg(REG_GRID_HIGH_2, hi[2]);
  endtask

  task automatic push_centre(input int c0, input int c1, input int c2);
    coord_vec_t c;
    c[0] = COORD_BITS'(c0);
    c[1] = COORD_BITS'(c1);
    c[2] = COORD_BITS'(c2);
    pending_centres.push_back(c);
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_centres.size() != 0 || in_tvalid || expected_cells.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // centres biased towards the clipping edges of the current grid
  function automatic logic [COORD_BITS-1:0] pick_coord(input int d);
    case ($urandom_range(9))
      0:       return grid_low[d];
      1:       return grid_low[d] - 1'b1;
      2:       return grid_low[d] + 1'b1;
      3:       return COORD_BITS'(grid_high[d] - 1'b1);
      4:       return COORD_BITS'(grid_high[d] - 2'd2);
      5:       return COORD_BITS'(grid_high[d]);
      6:       return '0;
      7:       return COORD_BITS'(COORD_TOP);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_high(input int lo);
    case ($urandom_range(7))
      0:       return $urandom_range(BOUND_TOP);
      1:       return lo + 1;
      2:       return lo + 2;
      3:       return lo + 3;
      4:       return 1 << COORD_BITS;
      5:       return 0;
      6:       return 1;
      default: return BOUND_TOP;
    endcase
  endfunction

  initial begin
    int lo[MAX_DIMS];
    int hi[MAX_DIMS];
    int dims;
    for (int d = 0; d < MAX_DIMS; d++) begin
      grid_low[d]  = '0;
      grid_high[d] = GRID_HIGH_RST;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full 3-D grid, floor and ceiling of the coordinates
    push_centre(0, 0, 0);
    push_centre(COORD_TOP, COORD_TOP, COORD_TOP);
    push_centre(2048, 2048, 2048);
    push_centre(0, COORD_TOP, 1);
    push_centre(COORD_TOP - 1, 1, COORD_TOP);
    push_centre(1, COORD_TOP - 1, 0);
    wait_idle();

    // count of zero acts as one; centres on, beside and outside the grid
    lo = '{7, 300, 0};
    hi = '{9, 0, 1};
    program_grid(0, lo, hi);
    push_centre(7, 123, 456);
    push_centre(8, COORD_TOP, 0);
    push_centre(6, 0, COORD_TOP);
    push_centre(9, 1, 2);
    push_centre(0, 77, 88);
    push_centre(COORD_TOP, COORD_TOP, COORD_TOP);
    wait_idle();

    // two dims: window collapsed to the centre, zero upper bound
    lo = '{0, COORD_TOP, 5};
    hi = '{1, 0, BOUND_TOP};
    program_grid(2, lo, hi);
    push_centre(0, COORD_TOP, 5);
    push_centre(3, COORD_TOP - 1, 6);
    push_centre(0, 0, 0);
    wait_idle();

    // three dims with the top bound at its widest
    lo = '{100, 0, COORD_TOP};
    hi = '{101, BOUND_TOP, 1 << COORD_BITS};
    program_grid(3, lo, hi);
    push_centre(100, 5, COORD_TOP);
    push_centre(101, 0, COORD_TOP - 1);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      dims = (p == 3) ? 0 : (p == 0 || p == 4) ? 3 : $urandom_range(3);
      for (int d = 0; d < MAX_DIMS; d++) begin
        case (p)
          0:       begin lo[d] = 0;         hi[d] = 1 << COORD_BITS; end
          4:       begin lo[d] = COORD_TOP; hi[d] = BOUND_TOP;       end
          6:       begin lo[d] = 0;         hi[d] = 1;               end
          default: begin
            lo[d] = $urandom_range(COORD_TOP);
            hi[d] = pick_high(lo[d]);
          end
        endcase
      end
      program_grid(dims, lo, hi);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_centre(pick_coord(0), pick_coord(1), pick_coord(2));
      // the sender holds off here until the whole phase has drained
      wait_idle();
    end

    if (mismatches == 0 && expected_cells.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- moore_neighborhood_generator.f -----
src/mng_pkg.sv
src/mng_front.sv
src/mng_queue.sv
src/mng_back.sv
src/moore_neighborhood_generator.sv
src/mng_checker.sv
verif/tb_moore_neighborhood_generator.sv
